### hw/rtl/sequential_list_engine_defines.svh
// assertion macros for the sequential list engine
// used by modules that assert; expects clk_i and rst_ni in scope
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sle_pkg.sv
// shared types and constants for the sequential list engine
// no dependencies
package sle_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_ALTER    = 3'd2,
    OP_LOCATE   = 3'd3,
    OP_TRAVERSE = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_BADPOS = 2'd2,
    STS_NONE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHUP,
    ST_SHDN,
    ST_SCAN,
    ST_LOCEND,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                     valid;
    status_e                  status;
    logic [POS_W-1:0]         found_position;
    logic signed [ELEM_W-1:0] element;
    logic                     last;
    logic [POS_W-1:0]         count;
  } res_t;

endpackage

### hw/rtl/sle_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sle_seq.sv
// list engine sequencer: decodes an op, walks the ram one entry a cycle unless stalled
// depends on sle_pkg and sequential_list_engine_defines.svh
`include "sequential_list_engine_defines.svh"

module sle_seq import sle_pkg::*; #(
  parameter int unsigned Depth = DEPTH_DEF,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [ELEM_W-1:0] value_i,
  input  logic                     out_free_i,
  output res_t                     res_o,
  output logic                     mem_we_o,
  output logic [AddrW-1:0]         mem_waddr_o,
  output logic [ELEM_W-1:0]        mem_wdata_o,
  output logic [AddrW-1:0]         mem_raddr_o,
  input  logic [ELEM_W-1:0]        mem_rdata_i
);

  localparam logic [POS_W-1:0] DepthC = POS_W'(Depth);
  localparam logic [POS_W-1:0] One    = POS_W'(1);

  state_e                   state_q, state_d;
  logic [AddrW-1:0]         idx_q, idx_d;
  logic [POS_W-1:0]         cnt_q, cnt_d;
  op_e                      op_q, op_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic signed [ELEM_W-1:0] val_q, val_d;
  status_e                  status_q, status_d;
  logic                     pend_valid_q, pend_valid_d;
  logic [POS_W-1:0]         pend_pos_q, pend_pos_d;

  logic [POS_W-1:0] idx_ext;
  logic [POS_W-1:0] cnt_new;
  logic             is_last;
  logic             hit;

  assign idx_ext     = POS_W'(idx_q);
  assign is_last     = (idx_ext == cnt_q - One);
  assign hit         = (mem_rdata_i == val_q);
  assign mem_raddr_o = idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    op_q       <= op_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    status_q   <= status_d;
    pend_pos_q <= pend_pos_d;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    pos_d        = pos_q;
    val_d        = val_q;
    status_d     = status_q;
    pend_valid_d = pend_valid_q;
    pend_pos_d   = pend_pos_q;
    cnt_new      = cnt_q;
    in_ready_o   = 1'b0;
    res_o        = '0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = idx_q;
    mem_wdata_o  = mem_rdata_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d         = op_e'(opcode_i);
          pos_d        = position_i;
          val_d        = value_i;
          status_d     = STS_OK;
          pend_valid_d = 1'b0;
          state_d      = ST_RESP;
          case (opcode_i) inside
            OP_INSERT: begin
              if (cnt_q >= DepthC) begin
                status_d = STS_FULL;
              end else if (position_i == '0 || position_i > cnt_q + One) begin
                status_d = STS_BADPOS;
              end else if (position_i <= cnt_q) begin
                // move entries up starting from the top one
                state_d = ST_SHUP;
                idx_d   = AddrW'(cnt_q - One);
              end
            end
            OP_DELETE: begin
              if (position_i == '0 || position_i > cnt_q) begin
                status_d = STS_BADPOS;
              end else if (position_i < cnt_q) begin
                // first source is the entry just past the removed one
                state_d = ST_SHDN;
                idx_d   = AddrW'(position_i);
              end
            end
            OP_ALTER: begin
              if (position_i == '0 || position_i > cnt_q) begin
                status_d = STS_BADPOS;
              end
            end
            OP_LOCATE, OP_TRAVERSE: begin
              if (cnt_q == '0) begin
                status_d = STS_NONE;
              end else begin
                state_d = ST_SCAN;
                idx_d   = '0;
              end
            end
            default: status_d = STS_BADPOS;
          endcase
        end
      end

      ST_SHUP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(idx_ext + One);
        if (idx_ext == pos_q - One) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q - AddrW'(1);
        end
      end

      ST_SHDN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(idx_ext - One);
        if (is_last) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end

      ST_SCAN: begin
        if (op_q == OP_TRAVERSE) begin
          if (out_free_i) begin
            res_o.valid          = 1'b1;
            res_o.status         = STS_OK;
            res_o.found_position = idx_ext + One;
            res_o.element        = mem_rdata_i;
            res_o.last           = is_last;
            res_o.count          = cnt_q;
            if (is_last) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + AddrW'(1);
            end
          end
        end else if (!(hit && pend_valid_q && !out_free_i)) begin
          // a match is held back until the next one, so the final one can carry last
          if (hit && pend_valid_q) begin
            res_o.valid          = 1'b1;
            res_o.status         = STS_OK;
            res_o.found_position = pend_pos_q;
            res_o.element        = val_q;
            res_o.last           = 1'b0;
            res_o.count          = cnt_q;
          end
          if (hit) begin
            pend_valid_d = 1'b1;
            pend_pos_d   = idx_ext + One;
          end
          if (is_last) begin
            state_d = ST_LOCEND;
          end else begin
            idx_d = idx_q + AddrW'(1);
          end
        end
      end

      ST_LOCEND: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.last  = 1'b1;
          res_o.count = cnt_q;
          if (pend_valid_q) begin
            res_o.status         = STS_OK;
            res_o.found_position = pend_pos_q;
            res_o.element        = val_q;
          end else begin
            res_o.status = STS_NONE;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (out_free_i) begin
          if (status_q == STS_OK) begin
            case (op_q)
              OP_INSERT: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AddrW'(pos_q - One);
                mem_wdata_o = val_q;
                cnt_new     = cnt_q + One;
              end
              OP_DELETE: cnt_new = cnt_q - One;
              OP_ALTER: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AddrW'(pos_q - One);
                mem_wdata_o = val_q;
              end
              default: cnt_new = cnt_q;
            endcase
          end
          cnt_d        = cnt_new;
          res_o.valid  = 1'b1;
          res_o.status = status_q;
          res_o.last   = 1'b1;
          res_o.count  = cnt_new;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  `SLE_ASSERT_SAME(a_idle_no_write, state_q == ST_IDLE, !mem_we_o, "ram written while idle")
  `SLE_ASSERT_SAME(a_emit_free, res_o.valid, out_free_i, "result issued into full output")
  `SLE_ASSERT_NEXT(a_cnt_hold, state_q != ST_RESP, cnt_q == $past(cnt_q), "count moved early")
  `SLE_ASSERT_SAME(a_pend_scope, pend_valid_q, state_q == ST_SCAN || state_q == ST_LOCEND,
                   "pending match outside locate")

endmodule

### hw/rtl/sequential_list_engine.sv
// sequential list engine top: ram, sequencer and one output register; depends on sle_pkg
// single-result ops go straight to the response; insert and delete first shift entries
// one by one; locate and traverse read one entry a cycle while the output can take results
// one transaction in flight; ready again once its final result is in the output register
// rst_ni async active low clears state, count and output valid; ram contents are not cleared
module sequential_list_engine import sle_pkg::*; #(
  parameter int unsigned Depth = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [ELEM_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [POS_W-1:0]         found_position_o,
  output logic signed [ELEM_W-1:0] element_o,
  output logic                     last_o,
  output logic [POS_W-1:0]         count_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  res_t              res;
  res_t              out_q;
  logic              out_valid_q;
  logic              out_free;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [ELEM_W-1:0] mem_rdata;

  assign out_free = !out_valid_q || out_ready_i;

  sle_seq #(
    .Depth(Depth)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .value_i    (value_i),
    .out_free_i (out_free),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  sle_ram #(
    .Width(ELEM_W),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register: refills in the same cycle the previous result leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign found_position_o = out_q.found_position;
  assign element_o        = out_q.element;
  assign last_o           = out_q.last;
  assign count_o          = out_q.count;

endmodule
